/* design/aging_route_table_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the aging route table core
// Concurrent assertion wrappers; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef AGING_ROUTE_TABLE_CORE_DEFINES_SVH
`define AGING_ROUTE_TABLE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Assert a property on a named clock, disabled while the reset is low
`define ART_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the block clock and reset
`define ART_ASSERT(lbl, prop, msg) \
  `ART_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define ART_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ART_ASSERT(lbl, prop, msg)

`endif

`endif

/* design/art_pkg.sv */
// ----------------------------------------------------------------------------
// Aging route table package
// Field widths, request codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package art_pkg;

  // Field widths
  localparam int REQ_W     = 3;
  localparam int DEST_W    = 16;
  localparam int HOP_W     = 16;
  localparam int HOPS_W    = 8;
  localparam int SEQ_W     = 8;
  localparam int POS_W     = 3;
  localparam int AGE_W     = 8;
  localparam int LIFE_W    = 8;
  localparam int TOTAL_W   = 4;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // Lifetime after reset, in ticks
  localparam logic [LIFE_W-1:0] LIFE_RESET = 8'd60;

  // Request codes; the two remaining codes answer like a miss
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FLUSH  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_GET    = 3'd5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;      // capture the request transaction
    logic search;     // match entries and register the chosen slot
    logic exec;       // apply the request to the table
    logic tick_step;  // age one slot and drop it if expired
    logic load_out;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic req_tick;   // latched request is a tick
    logic tick_last;  // tick step is at the last slot
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

/* design/art_ctrl.sv */
// ----------------------------------------------------------------------------
// Aging route table controller
// Sequences accept, search, execute or tick sweep, and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module art_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire art_pkg::sts_t sts_i,
  output art_pkg::cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_TICK   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = sts_i.req_tick ? ST_TICK : ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (sts_i.tick_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* design/art_dpath.sv */
// ----------------------------------------------------------------------------
// Aging route table datapath
// Match cells with valid, rank and age per slot, payload memory, result reg.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aging_route_table_core_defines.svh"

module art_dpath #(
  parameter int TABLE_ENTRIES = 8,
  parameter int ADDR_BITS     = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [art_pkg::LIFE_W-1:0]         cfg_wdata_i,
  // request fields
  input  wire logic [art_pkg::REQ_W-1:0]          req_type_i,
  input  wire logic [art_pkg::DEST_W-1:0]         dest_addr_i,
  input  wire logic [art_pkg::HOP_W-1:0]          next_hop_in_i,
  input  wire logic [art_pkg::HOPS_W-1:0]         hops_in_i,
  input  wire logic [art_pkg::SEQ_W-1:0]          seq_in_i,
  input  wire logic [art_pkg::POS_W-1:0]          position_i,
  // control
  input  wire art_pkg::cmd_t                      cmd_i,
  output art_pkg::sts_t                           sts_o,
  // result
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic                                    found_o,
  output logic [art_pkg::DEST_W-1:0]              dest_out_o,
  output logic [art_pkg::HOP_W-1:0]               next_hop_out_o,
  output logic [art_pkg::HOPS_W-1:0]              hops_out_o,
  output logic [art_pkg::SEQ_W-1:0]               seq_out_o,
  output logic                                    evicted_o,
  output logic [art_pkg::TOTAL_W-1:0]             entry_total_o
);

  localparam int N      = TABLE_ENTRIES;
  localparam int DW     = (ADDR_BITS < art_pkg::DEST_W) ? ADDR_BITS : art_pkg::DEST_W;
  localparam int IDX_W  = (N > 1) ? $clog2(N) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(N + 1);
  localparam int CMP_A  = (RANK_W > art_pkg::POS_W) ? RANK_W : art_pkg::POS_W;
  localparam int CMP_W  = (CMP_A > CNT_W) ? CMP_A : CNT_W;
  localparam int MEM_W  = DW + art_pkg::HOP_W + art_pkg::HOPS_W + art_pkg::SEQ_W;
  localparam logic [art_pkg::AGE_W-1:0] AGE_MAX = '1;

  // Latched request
  logic [art_pkg::REQ_W-1:0]  req_q;
  logic [DW-1:0]              dest_q;
  logic [art_pkg::HOP_W-1:0]  nh_q;
  logic [art_pkg::HOPS_W-1:0] hops_q;
  logic [art_pkg::SEQ_W-1:0]  seq_q;
  logic [art_pkg::POS_W-1:0]  pos_q;

  // Table cells
  logic [N-1:0]               valid_q, valid_d;
  logic [RANK_W-1:0]          rank_q [N];
  logic [RANK_W-1:0]          rank_d [N];
  logic [art_pkg::AGE_W-1:0]  age_q [N];
  logic [art_pkg::AGE_W-1:0]  age_d [N];
  logic [DW-1:0]              cdest_q [N];
  logic [DW-1:0]              cdest_d [N];
  logic [CNT_W-1:0]           count_q, count_d;
  logic [art_pkg::LIFE_W-1:0] life_q;
  logic [IDX_W-1:0]           idx_q;

  // Payload memory
  logic [MEM_W-1:0]           mem_q [N];
  logic [MEM_W-1:0]           rd_q;

  // Search results
  logic                       hit_q, full_q, pos_hit_q;
  logic [IDX_W-1:0]           slot_q;

  // Result register
  logic                       out_valid_q;
  logic                       found_q, evicted_q;
  logic [art_pkg::DEST_W-1:0] dout_q;
  logic [art_pkg::HOP_W-1:0]  nhout_q;
  logic [art_pkg::HOPS_W-1:0] hout_q;
  logic [art_pkg::SEQ_W-1:0]  sout_q;
  logic [art_pkg::TOTAL_W-1:0] total_q;

  // Capture the request transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= req_type_i;
      dest_q <= dest_addr_i[DW-1:0];
      nh_q   <= next_hop_in_i;
      hops_q <= hops_in_i;
      seq_q  <= seq_in_i;
      pos_q  <= position_i;
    end
  end

  // Lifetime register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q <= art_pkg::LIFE_RESET;
    end else if (cfg_we_i) begin
      life_q <= cfg_wdata_i;
    end
  end

  // Match all cells and pick the lowest-numbered slot of each kind
  logic [N-1:0]     hit_vec, free_vec, old_vec, pos_vec;
  logic [IDX_W-1:0] hit_idx, free_idx, old_idx, pos_idx, slot_d;
  logic             pos_ok;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    old_idx  = IDX_W'(N - 1);
    pos_idx  = '0;
    for (int i = 0; i < N; i++) begin
      hit_vec[i]  = valid_q[i] && (cdest_q[i] == dest_q);
      free_vec[i] = !valid_q[i];
      old_vec[i]  = (rank_q[i] == RANK_W'(N - 1));
      pos_vec[i]  = valid_q[i] && (CMP_W'(rank_q[i]) == CMP_W'(pos_q));
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_idx  = IDX_W'(i);
      if (free_vec[i]) free_idx = IDX_W'(i);
      if (old_vec[i])  old_idx  = IDX_W'(i);
      if (pos_vec[i])  pos_idx  = IDX_W'(i);
    end
    pos_ok = CMP_W'(pos_q) < CMP_W'(count_q);
    case (req_q)
      art_pkg::REQ_ADD: begin
        if (|hit_vec) begin
          slot_d = hit_idx;
        end else if (|free_vec) begin
          slot_d = free_idx;
        end else begin
          slot_d = old_idx;
        end
      end
      art_pkg::REQ_GET: begin
        slot_d = pos_idx;
      end
      default: begin
        slot_d = hit_idx;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      full_q    <= 1'b0;
      pos_hit_q <= 1'b0;
      slot_q    <= '0;
    end else if (cmd_i.search) begin
      hit_q     <= |hit_vec;
      full_q    <= ~|free_vec;
      pos_hit_q <= pos_ok && (|pos_vec);
      slot_q    <= slot_d;
    end
  end

  // Tick sweep counter: one slot per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.latch) begin
      idx_q <= '0;
    end else if (cmd_i.tick_step && (idx_q != IDX_W'(N - 1))) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // Cell updates for execute and tick steps
  logic [RANK_W-1:0]         r_sel, r_tick;
  logic [art_pkg::AGE_W-1:0] a_tick, tick_age;
  logic                      add_unlink, tick_drop;

  always_comb begin
    r_sel      = rank_q[slot_q];
    r_tick     = rank_q[idx_q];
    a_tick     = age_q[idx_q];
    tick_age   = (a_tick == AGE_MAX) ? a_tick : a_tick + art_pkg::AGE_W'(1);
    tick_drop  = tick_age >= life_q;
    add_unlink = hit_q || full_q;
    valid_d    = valid_q;
    rank_d     = rank_q;
    age_d      = age_q;
    cdest_d    = cdest_q;
    count_d    = count_q;

    if (cmd_i.exec) begin
      case (req_q)
        art_pkg::REQ_ADD: begin
          // shift everyone back one, closing the gap left by an unlinked slot
          for (int i = 0; i < N; i++) begin
            if (valid_q[i] && (IDX_W'(i) != slot_q)) begin
              if (!(add_unlink && (rank_q[i] > r_sel))) begin
                rank_d[i] = rank_q[i] + RANK_W'(1);
              end
            end
          end
          valid_d[slot_q] = 1'b1;
          rank_d[slot_q]  = '0;
          age_d[slot_q]   = '0;
          cdest_d[slot_q] = dest_q;
          if (!add_unlink) begin
            count_d = count_q + CNT_W'(1);
          end
        end
        art_pkg::REQ_LOOKUP: begin
          if (hit_q) begin
            age_d[slot_q] = '0;
          end
        end
        art_pkg::REQ_REMOVE: begin
          if (hit_q) begin
            for (int i = 0; i < N; i++) begin
              if (valid_q[i] && (rank_q[i] > r_sel)) begin
                rank_d[i] = rank_q[i] - RANK_W'(1);
              end
            end
            valid_d[slot_q] = 1'b0;
            rank_d[slot_q]  = '0;
            if (count_q != '0) begin
              count_d = count_q - CNT_W'(1);
            end
          end
        end
        art_pkg::REQ_FLUSH: begin
          valid_d = '0;
          rank_d  = '{default: '0};
          count_d = '0;
        end
        default: begin
        end
      endcase
    end

    // Age one slot; drop it once it reaches the lifetime
    if (cmd_i.tick_step && valid_q[idx_q]) begin
      age_d[idx_q] = tick_age;
      if (tick_drop) begin
        for (int i = 0; i < N; i++) begin
          if (valid_q[i] && (rank_q[i] > r_tick)) begin
            rank_d[i] = rank_q[i] - RANK_W'(1);
          end
        end
        valid_d[idx_q] = 1'b0;
        rank_d[idx_q]  = '0;
        if (count_q != '0) begin
          count_d = count_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '{default: '0};
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q   <= age_d;
    cdest_q <= cdest_d;
  end

  // Payload memory: write on add, registered read on execute
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (req_q == art_pkg::REQ_ADD)) begin
      mem_q[slot_q] <= {dest_q, nh_q, hops_q, seq_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_q <= mem_q[slot_q];
    end
  end

  // Form the result
  logic [DW-1:0]              rd_dest;
  logic [art_pkg::HOP_W-1:0]  rd_nh;
  logic [art_pkg::HOPS_W-1:0] rd_hops;
  logic [art_pkg::SEQ_W-1:0]  rd_seq;
  logic                       found_d, evicted_d, use_rd;
  logic [art_pkg::DEST_W-1:0] dout_d;
  logic [art_pkg::HOP_W-1:0]  nhout_d;
  logic [art_pkg::HOPS_W-1:0] hout_d;
  logic [art_pkg::SEQ_W-1:0]  sout_d;

  assign rd_seq  = rd_q[art_pkg::SEQ_W-1:0];
  assign rd_hops = rd_q[art_pkg::SEQ_W +: art_pkg::HOPS_W];
  assign rd_nh   = rd_q[art_pkg::SEQ_W + art_pkg::HOPS_W +: art_pkg::HOP_W];
  assign rd_dest = rd_q[MEM_W-1 -: DW];

  always_comb begin
    found_d   = 1'b0;
    evicted_d = 1'b0;
    use_rd    = 1'b0;
    dout_d    = '0;
    nhout_d   = '0;
    hout_d    = '0;
    sout_d    = '0;
    case (req_q)
      art_pkg::REQ_ADD: begin
        found_d   = hit_q;
        evicted_d = !hit_q && full_q;
        dout_d    = art_pkg::DEST_W'(dest_q);
        nhout_d   = nh_q;
        hout_d    = hops_q;
        sout_d    = seq_q;
      end
      art_pkg::REQ_LOOKUP, art_pkg::REQ_REMOVE: begin
        found_d = hit_q;
        use_rd  = hit_q;
      end
      art_pkg::REQ_GET: begin
        found_d = pos_hit_q;
        use_rd  = pos_hit_q;
      end
      default: begin
      end
    endcase
    if (use_rd) begin
      dout_d  = art_pkg::DEST_W'(rd_dest);
      nhout_d = rd_nh;
      hout_d  = rd_hops;
      sout_d  = rd_seq;
    end
  end

  // Result register: hold until the receiver takes the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      found_q   <= found_d;
      evicted_q <= evicted_d;
      dout_q    <= dout_d;
      nhout_q   <= nhout_d;
      hout_q    <= hout_d;
      sout_q    <= sout_d;
      total_q   <= art_pkg::TOTAL_W'(count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign dest_out_o     = dout_q;
  assign next_hop_out_o = nhout_q;
  assign hops_out_o     = hout_q;
  assign seq_out_o      = sout_q;
  assign evicted_o      = evicted_q;
  assign entry_total_o  = total_q;

  // Status to the controller
  assign sts_o.req_tick  = (req_q == art_pkg::REQ_TICK);
  assign sts_o.tick_last = (idx_q == IDX_W'(N - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Checks
  `ART_ASSERT(a_count_tracks_valid, ($countones(valid_q) == int'(count_q)), "count out of step with valid bits")
  `ART_ASSERT(a_flush_clears, (cmd_i.exec && (req_q == art_pkg::REQ_FLUSH)) |=> (valid_q == '0), "flush left entries valid")
  `ART_ASSERT(a_add_at_front, (cmd_i.exec && (req_q == art_pkg::REQ_ADD)) |=> (valid_q[slot_q] && (rank_q[slot_q] == '0)), "added entry not newest")
  `ART_ASSERT(a_load_when_free, cmd_i.load_out |-> (!out_valid_q || out_ready_i), "result overwritten before taken")

endmodule

`default_nettype wire

/* design/aging_route_table_core.sv */
// ----------------------------------------------------------------------------
// Aging route table core
// Route table kept newest first, oldest entry evicted, aging by tick request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the slave stream: the request code on s_axis_tuser and
//   destination, next hop, hop count, sequence and position on s_axis_tdata.
//   Each request yields exactly one result transaction on the master stream.
//   Add, lookup, remove, flush and get pass from acceptance to the result
//   register through accept, match search over all slots, table update with
//   payload memory read and result load. A tick sweeps the slots one per
//   cycle in place of the update. One request is in work at a time.
//   A new request is accepted as soon as the previous result sits in the
//   output register, even while the receiver stalls; a stalled receiver
//   holds the result and blocks only the load of the next one.
//   The lifetime register is to be written (cfg_we_i/cfg_wdata_i) only while
//   idle; the block does not enforce it. Reset empties the table (valid bits
//   and count cleared), restores a 60-tick lifetime; no clearing pass needed.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_route_table_core #(
  parameter int TABLE_ENTRIES = 8,
  parameter int ADDR_BITS     = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // lifetime register write
  input  wire logic                              cfg_we_i,
  input  wire logic [art_pkg::LIFE_W-1:0]        cfg_wdata_i,
  // request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [15:0] dest_addr, [31:16] next_hop_in, [39:32] hops_in,
  // [47:40] seq_in, [50:48] position, [55:51] zero
  input  wire logic [art_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [2:0] req_type
  input  wire logic [art_pkg::REQ_W-1:0]         s_axis_tuser,
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] found, [16:1] dest_out, [32:17] next_hop_out, [40:33] hops_out,
  // [48:41] seq_out, [49] evicted, [53:50] entry_total, [55:54] zero
  output logic [art_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

  art_pkg::cmd_t cmd;
  art_pkg::sts_t sts;

  logic                        found;
  logic                        evicted;
  logic [art_pkg::DEST_W-1:0]  dest_out;
  logic [art_pkg::HOP_W-1:0]   next_hop_out;
  logic [art_pkg::HOPS_W-1:0]  hops_out;
  logic [art_pkg::SEQ_W-1:0]   seq_out;
  logic [art_pkg::TOTAL_W-1:0] entry_total;

  // Sequencer
  art_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table and result datapath
  art_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDR_BITS     (ADDR_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (s_axis_tuser),
    .dest_addr_i    (s_axis_tdata[15:0]),
    .next_hop_in_i  (s_axis_tdata[31:16]),
    .hops_in_i      (s_axis_tdata[39:32]),
    .seq_in_i       (s_axis_tdata[47:40]),
    .position_i     (s_axis_tdata[50:48]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .found_o        (found),
    .dest_out_o     (dest_out),
    .next_hop_out_o (next_hop_out),
    .hops_out_o     (hops_out),
    .seq_out_o      (seq_out),
    .evicted_o      (evicted),
    .entry_total_o  (entry_total)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = {2'b00, entry_total, evicted, seq_out, hops_out,
                         next_hop_out, dest_out, found};

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Aging route table core testbench
// Drives route requests on the request stream and checks every result
// transaction field by field against an in-bench model of the table. A short
// table of directed requests covers the empty table, field extremes,
// duplicates, eviction, out-of-range gets and the spare request codes. Random
// phases then run under several lifetimes, with random idling on both streams
// and one long receiver stall.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 8;
  localparam int ENTRIES       = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 200;
  localparam int POOL_SIZE     = 12;

  // Spare request codes; the table answers them like a miss
  localparam logic [art_pkg::REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [art_pkg::REQ_W-1:0] REQ_SPARE7 = 3'd7;

  typedef struct packed {
    logic [art_pkg::REQ_W-1:0]  kind;
    logic [art_pkg::DEST_W-1:0] dest;
    logic [art_pkg::HOP_W-1:0]  next_hop;
    logic [art_pkg::HOPS_W-1:0] hops;
    logic [art_pkg::SEQ_W-1:0]  seq;
    logic [art_pkg::POS_W-1:0]  pos;
  } route_req_t;

  typedef struct packed {
    logic                        found;
    logic [art_pkg::DEST_W-1:0]  dest;
    logic [art_pkg::HOP_W-1:0]   next_hop;
    logic [art_pkg::HOPS_W-1:0]  hops;
    logic [art_pkg::SEQ_W-1:0]   seq;
    logic                        evicted;
    logic [art_pkg::TOTAL_W-1:0] total;
  } route_rsp_t;

  typedef struct {
    route_req_t req;
    bit         typed;
    route_rsp_t rsp;
  } directed_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [art_pkg::LIFE_W-1:0]       cfg_wdata_i;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [art_pkg::IN_DATA_W-1:0]    s_axis_tdata;
  logic [art_pkg::REQ_W-1:0]        s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [art_pkg::OUT_DATA_W-1:0]   m_axis_tdata;

  // Shadow route table
  logic [art_pkg::DEST_W-1:0] tbl_dest     [ENTRIES];
  logic [art_pkg::HOP_W-1:0]  tbl_next_hop [ENTRIES];
  logic [art_pkg::HOPS_W-1:0] tbl_hops     [ENTRIES];
  logic [art_pkg::SEQ_W-1:0]  tbl_seq      [ENTRIES];
  logic [art_pkg::AGE_W-1:0]  tbl_age      [ENTRIES];
  bit                         tbl_valid    [ENTRIES];
  int                         tbl_rank     [ENTRIES];
  int                         tbl_count;
  logic [art_pkg::LIFE_W-1:0] lifetime_q;

  route_rsp_t                 route_expect_q[$];
  directed_row_t              directed_rows[$];
  logic [art_pkg::DEST_W-1:0] dest_pool [POOL_SIZE];
  int                         mismatch_count = 0;
  int                         tx_idle_pct = 0;
  int                         rx_idle_pct = 0;
  bit                         hold_pending = 1'b0;
  int                         hold_left = 0;
  int                         stall_cycles = 0;

  aging_route_table_core #(
    .TABLE_ENTRIES(ENTRIES),
    .ADDR_BITS    (art_pkg::DEST_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------
  function automatic int find_slot(logic [art_pkg::DEST_W-1:0] d);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_dest[i] == d) return i;
    end
    return -1;
  endfunction

  // Unlink a slot and close the gap in the newest-first order
  function automatic void drop_slot(int s);
    int r;
    r = tbl_rank[s];
    tbl_valid[s] = 1'b0;
    tbl_rank[s]  = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
    end
    if (tbl_count > 0) tbl_count--;
  endfunction

  function automatic route_rsp_t slot_result(int s);
    route_rsp_t rsp;
    rsp          = '0;
    rsp.found    = 1'b1;
    rsp.dest     = tbl_dest[s];
    rsp.next_hop = tbl_next_hop[s];
    rsp.hops     = tbl_hops[s];
    rsp.seq      = tbl_seq[s];
    return rsp;
  endfunction

  function automatic route_rsp_t predict_route(route_req_t r);
    route_rsp_t rsp;
    int         s;
    bit         dup;
    bit         ev;
    rsp = '0;
    dup = 1'b0;
    ev  = 1'b0;
    s   = -1;
    case (r.kind)
      art_pkg::REQ_ADD: begin
        s = find_slot(r.dest);
        if (s >= 0) begin
          dup = 1'b1;
          drop_slot(s);
        end else begin
          for (int i = 0; i < ENTRIES && s < 0; i++) begin
            if (!tbl_valid[i]) s = i;
          end
          // Full table: reuse the slot of the oldest entry
          if (s < 0) begin
            s = ENTRIES - 1;
            for (int i = ENTRIES - 1; i >= 0; i--) begin
              if (tbl_rank[i] == ENTRIES - 1) s = i;
            end
            drop_slot(s);
            ev = 1'b1;
          end
        end
        tbl_dest[s]     = r.dest;
        tbl_next_hop[s] = r.next_hop;
        tbl_hops[s]     = r.hops;
        tbl_seq[s]      = r.seq;
        tbl_age[s]      = '0;
        // Push the entry to the front
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i]) tbl_rank[i]++;
        end
        tbl_valid[s] = 1'b1;
        tbl_rank[s]  = 0;
        tbl_count++;
        rsp         = slot_result(s);
        rsp.found   = dup;
        rsp.evicted = ev;
      end
      art_pkg::REQ_LOOKUP: begin
        s = find_slot(r.dest);
        if (s >= 0) begin
          tbl_age[s] = '0;
          rsp = slot_result(s);
        end
      end
      art_pkg::REQ_REMOVE: begin
        s = find_slot(r.dest);
        if (s >= 0) begin
          rsp = slot_result(s);
          drop_slot(s);
        end
      end
      art_pkg::REQ_FLUSH: begin
        for (int i = 0; i < ENTRIES; i++) begin
          tbl_valid[i] = 1'b0;
          tbl_rank[i]  = 0;
        end
        tbl_count = 0;
      end
      art_pkg::REQ_TICK: begin
        // Age every entry, saturating, and drop the expired ones
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_age[i] != '1) tbl_age[i]++;
            if (tbl_age[i] >= lifetime_q) drop_slot(i);
          end
        end
      end
      art_pkg::REQ_GET: begin
        if (r.pos < tbl_count) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_rank[i] == r.pos) rsp = slot_result(i);
          end
        end
      end
      default: ;
    endcase
    rsp.total = tbl_count[art_pkg::TOTAL_W-1:0];
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic route_rsp_t miss_rsp(logic [art_pkg::TOTAL_W-1:0] n);
    route_rsp_t rsp;
    rsp       = '0;
    rsp.total = n;
    return rsp;
  endfunction

  task automatic push_row(logic [art_pkg::REQ_W-1:0]  kind,
                          logic [art_pkg::DEST_W-1:0] dest,
                          logic [art_pkg::HOP_W-1:0]  next_hop,
                          logic [art_pkg::HOPS_W-1:0] hops,
                          logic [art_pkg::SEQ_W-1:0]  seq,
                          logic [art_pkg::POS_W-1:0]  pos,
                          bit typed, route_rsp_t rsp);
    directed_row_t row;
    row.req   = '{kind, dest, next_hop, hops, seq, pos};
    row.typed = typed;
    row.rsp   = rsp;
    directed_rows.push_back(row);
  endtask

  function automatic route_req_t random_request(int tick_pct);
    route_req_t r;
    int         roll;
    if ($urandom_range(0, 99) < 85) r.dest = dest_pool[$urandom_range(0, POOL_SIZE - 1)];
    else r.dest = art_pkg::DEST_W'($urandom);
    r.next_hop = art_pkg::HOP_W'($urandom);
    r.hops     = art_pkg::HOPS_W'($urandom);
    r.seq      = art_pkg::SEQ_W'($urandom);
    r.pos      = art_pkg::POS_W'($urandom);
    roll       = $urandom_range(0, 99);
    if (roll < tick_pct) begin
      r.kind = art_pkg::REQ_TICK;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 38)      r.kind = art_pkg::REQ_ADD;
      else if (roll < 60) r.kind = art_pkg::REQ_LOOKUP;
      else if (roll < 72) r.kind = art_pkg::REQ_REMOVE;
      else if (roll < 92) r.kind = art_pkg::REQ_GET;
      else if (roll < 96) r.kind = art_pkg::REQ_FLUSH;
      else if (roll < 98) r.kind = REQ_SPARE6;
      else                r.kind = REQ_SPARE7;
    end
    return r;
  endfunction

  // Offer one request transaction; entered and left at a falling edge
  task automatic send_request(route_req_t r, bit typed, route_rsp_t typed_rsp);
    route_rsp_t pred;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = r.kind;
    s_axis_tdata  = {5'b0, r.pos, r.seq, r.hops, r.next_hop, r.dest};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_route(r);
    route_expect_q.push_back(typed ? typed_rsp : pred);
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (route_expect_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic start_phase(logic [art_pkg::LIFE_W-1:0] life, int tx_pct, int rx_pct);
    cfg_wdata_i = life;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    lifetime_q  = life;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  task automatic run_random(int n_items, int tick_pct);
    foreach (dest_pool[i]) dest_pool[i] = art_pkg::DEST_W'($urandom);
    for (int k = 0; k < n_items; k++) begin
      send_request(random_request(tick_pct), 1'b0, '0);
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = art_pkg::REQ_ADD;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_rank[i]  = 0;
    end
    tbl_count  = 0;
    lifetime_q = art_pkg::LIFE_RESET;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests; empty table first, then extremes, duplicates, eviction
    push_row(art_pkg::REQ_LOOKUP, 16'h1234, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1, miss_rsp(4'd0));
    push_row(art_pkg::REQ_GET, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1, miss_rsp(4'd0));
    push_row(art_pkg::REQ_TICK, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1, miss_rsp(4'd0));
    push_row(art_pkg::REQ_FLUSH, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1, miss_rsp(4'd0));
    push_row(art_pkg::REQ_REMOVE, 16'hFFFF, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1, miss_rsp(4'd0));
    push_row(art_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 3'd0, 1'b1,
             route_rsp_t'{1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0, 4'd1});
    push_row(art_pkg::REQ_ADD, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd7, 1'b1,
             route_rsp_t'{1'b0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 4'd2});
    push_row(art_pkg::REQ_ADD, 16'hFFFF, 16'h1234, 8'h03, 8'h04, 3'd0, 1'b1,
             route_rsp_t'{1'b1, 16'hFFFF, 16'h1234, 8'h03, 8'h04, 1'b0, 4'd2});
    push_row(art_pkg::REQ_GET, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd1, 1'b0, '0);
    push_row(art_pkg::REQ_GET, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd2, 1'b1, miss_rsp(4'd2));
    push_row(art_pkg::REQ_LOOKUP, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b0, '0);
    push_row(art_pkg::REQ_REMOVE, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b0, '0);
    push_row(art_pkg::REQ_REMOVE, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1, miss_rsp(4'd1));
    for (int i = 1; i < ENTRIES; i++) begin
      push_row(art_pkg::REQ_ADD, art_pkg::DEST_W'(i), (i % 2) ? 16'hA5A5 : 16'h5A5A,
               art_pkg::HOPS_W'(i), art_pkg::SEQ_W'(8'hF0 | i), 3'd0, 1'b0, '0);
    end
    push_row(art_pkg::REQ_ADD, 16'h0100, 16'h8001, 8'h80, 8'h01, 3'd0, 1'b0, '0);
    push_row(art_pkg::REQ_GET, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd7, 1'b0, '0);
    push_row(REQ_SPARE6, 16'h0001, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1, miss_rsp(4'd8));
    push_row(REQ_SPARE7, 16'h0002, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1, miss_rsp(4'd8));
    push_row(art_pkg::REQ_TICK, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b0, '0);
    push_row(art_pkg::REQ_FLUSH, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1, miss_rsp(4'd0));

    tx_idle_pct = 32;
    rx_idle_pct = 72;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
    end
    drain_results();

    // Random phases: lifetime extremes first, then the idling swaps
    start_phase(8'd0, 32, 72);
    run_random(60, 20);
    start_phase(8'd1, 32, 72);
    run_random(100, 20);
    start_phase(8'd255, 32, 72);
    run_random(300, 50);
    start_phase(8'd3, 72, 32);
    run_random(300, 15);
    start_phase(8'd8, 72, 32);
    hold_pending = 1'b1;
    run_random(300, 15);
    start_phase(8'd2, 0, 0);
    run_random(240, 10);
    start_phase(8'd5, 0, 0);
    run_random(250, 25);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && route_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_ready
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatch_count++;
    end
  endfunction

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    route_rsp_t got;
    route_rsp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found    = m_axis_tdata[0];
      got.dest     = m_axis_tdata[16:1];
      got.next_hop = m_axis_tdata[32:17];
      got.hops     = m_axis_tdata[40:33];
      got.seq      = m_axis_tdata[48:41];
      got.evicted  = m_axis_tdata[49];
      got.total    = m_axis_tdata[53:50];
      if (route_expect_q.size() == 0) begin
        $error("result transaction with no request outstanding");
        mismatch_count++;
      end else begin
        want = route_expect_q.pop_front();
        check_field("found",        want.found,    got.found);
        check_field("dest_out",     want.dest,     got.dest);
        check_field("next_hop_out", want.next_hop, got.next_hop);
        check_field("hops_out",     want.hops,     got.hops);
        check_field("seq_out",      want.seq,      got.seq);
        check_field("evicted",      want.evicted,  got.evicted);
        check_field("entry_total",  want.total,    got.total);
      end
    end
  end

  // Abort when no transaction moves on either stream for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
